@@ sv/pfa_pkg.sv @@
// pfa_pkg: sizes, codes and types shared by the partition fit allocator.
// No dependencies.
package pfa_pkg;

  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W    = $clog2(PARTITIONS + 1);
  localparam int POLICY_W = 2;
  localparam int PIU_W    = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int PIDX_W   = 4;
  localparam int AMOUNT_W = 16;

  localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(16);

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

@@ sv/pfa_ram.sv @@
// pfa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/partition_fit_allocator_core.sv @@
// partition_fit_allocator_core: free-space table with first/best/worst-fit search.
// Depends on pfa_pkg and pfa_ram.
// Load word: written to the table on acceptance, no result. Allocate word: busy
// while up to 16 partitions are searched, one RAM read per cycle; the result
// strobe rises as busy falls; the receiver cannot stall.
// Reset: synchronous, active low; policy first-fit, 16 partitions; table undefined.
module partition_fit_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [pfa_pkg::PIDX_W-1:0]    in_partition_index,
  input  logic [pfa_pkg::AMOUNT_W-1:0]  in_amount,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [pfa_pkg::PIDX_W-1:0]    out_chosen_partition,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IW = pfa_pkg::IDX_W;
  localparam int CW = pfa_pkg::CNT_W;
  localparam int SW = pfa_pkg::SIZE_BITS;

  pfa_pkg::state_t state_r, state_nxt;
  logic [pfa_pkg::POLICY_W-1:0] policy_r;
  logic [pfa_pkg::PIU_W-1:0]    piu_r;

  logic [SW-1:0] req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [SW-1:0] best_r, best_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_granted_r, out_granted_nxt;
  logic [pfa_pkg::PIDX_W-1:0] out_chosen_r, out_chosen_nxt;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  logic          accept;
  logic [CW-1:0] count_sat;
  logic          fits, take, last;

  pfa_ram #(
    .WIDTH (SW),
    .DEPTH (pfa_pkg::PARTITIONS)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != pfa_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign count_sat = (32'(piu_r) > pfa_pkg::PARTITIONS) ? CW'(pfa_pkg::PARTITIONS)
                                                        : CW'(piu_r);

  // running pick over the word returned this cycle
  assign fits = (req_r <= ram_rdata);
  assign last = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (policy_r == pfa_pkg::POL_BEST) begin
        take = (ram_rdata < best_r);
      end else if (policy_r == pfa_pkg::POL_WORST) begin
        take = (ram_rdata > best_r);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    count_nxt       = count_r;
    issue_nxt       = issue_r;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt  = out_chosen_r;
    ram_we          = 1'b0;
    ram_waddr       = in_partition_index[IW-1:0];
    ram_wdata       = in_amount[SW-1:0];
    ram_re          = 1'b0;
    ram_raddr       = issue_r[IW-1:0];

    unique case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == pfa_pkg::FUNC_LOAD) begin
            ram_we = (32'(in_partition_index) < pfa_pkg::PARTITIONS);
          end else begin
            req_nxt   = in_amount[SW-1:0];
            count_nxt = count_sat;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            if (count_sat == '0) begin
              state_nxt = pfa_pkg::ST_DONE;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              rd_idx_nxt = '0;
              issue_nxt  = CW'(1);
              state_nxt  = pfa_pkg::ST_SCAN;
            end
          end
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (take) begin
          found_nxt = 1'b1;
          pick_nxt  = rd_idx_r;
          best_nxt  = ram_rdata;
        end
        if (issue_r < count_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = issue_r[IW-1:0];
          issue_nxt  = issue_r + CW'(1);
        end
        if (last) begin
          state_nxt = pfa_pkg::ST_DONE;
        end
      end
      pfa_pkg::ST_DONE: begin
        ram_we          = found_r;
        ram_waddr       = pick_r;
        ram_wdata       = best_r - req_r;
        out_valid_nxt   = 1'b1;
        out_granted_nxt = found_r;
        out_chosen_nxt  = found_r ? pfa_pkg::PIDX_W'(pick_r) : '0;
        state_nxt       = pfa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      policy_r    <= pfa_pkg::POL_FIRST;
      piu_r       <= pfa_pkg::PIU_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pfa_pkg::CFG_POLICY: policy_r <= cfg_wdata[pfa_pkg::POLICY_W-1:0];
          pfa_pkg::CFG_PARTS:  piu_r    <= cfg_wdata[pfa_pkg::PIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    count_r       <= count_nxt;
    issue_r       <= issue_nxt;
    rd_idx_r      <= rd_idx_nxt;
    found_r       <= found_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_granted          = out_granted_r;
  assign out_chosen_partition = out_chosen_r;

endmodule

@@ sv/pfa_checker.sv @@
// pfa_checker: port-level assertions for partition_fit_allocator_core, with bind.
// Depends on pfa_pkg.
module pfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_func,
  input logic                         out_valid,
  input logic                         out_granted,
  input logic [pfa_pkg::PIDX_W-1:0]   out_chosen_partition
);

  // an allocate word always occupies the core
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == pfa_pkg::FUNC_ALLOC) |=> busy)
    else $error("allocate word accepted without busy");

  // a load word never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == pfa_pkg::FUNC_LOAD) |=> !out_valid)
    else $error("result after load word");

  // result strobes are never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // a refused word reports partition zero
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> (out_chosen_partition == '0))
    else $error("refusal with non-zero partition");

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_func              (in_func),
  .out_valid            (out_valid),
  .out_granted          (out_granted),
  .out_chosen_partition (out_chosen_partition)
);

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for partition_fit_allocator_core (first/best/worst fit).
// Depends on pfa_pkg and the core RTL; directed table first, then random phases
// checked against an in-bench predictor of the free-space table.
`timescale 1ns / 1ps

module tb_top;
  import pfa_pkg::*;

  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;  // unused code, behaves as first-fit
  localparam int PLAN_LEN = 24;
  localparam int PHASES   = 8;

  typedef struct packed {
    logic                 granted;
    logic [PIDX_W-1:0]    chosen;
  } grant_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [CFG_W-1:0]     reg_val;
    logic                 func;
    logic [PIDX_W-1:0]    pidx;
    logic [AMOUNT_W-1:0]  amt;
    logic                 exp_fixed;
    grant_t               exp_w;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_func;
  logic [PIDX_W-1:0]     in_partition_index;
  logic [AMOUNT_W-1:0]   in_amount;
  logic                  out_valid;
  logic                  out_granted;
  logic [PIDX_W-1:0]     out_chosen_partition;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // predictor state
  logic [SIZE_BITS-1:0]  free_space [PARTITIONS];
  logic [POLICY_W-1:0]   pol;
  logic [PIU_W-1:0]      piu;
  grant_t                grant_q [$];

  int errors = 0;
  int n_words = 0;
  int n_loads = 0;
  int n_cfg = 0;
  int grants_seen = 0;
  int refusals_seen = 0;

  step_t                 plan [PLAN_LEN];
  logic [POLICY_W-1:0]   ph_pol [PHASES];
  logic [PIU_W-1:0]      ph_piu [PHASES];

  partition_fit_allocator_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_partition_index   (in_partition_index),
    .in_amount            (in_amount),
    .out_valid            (out_valid),
    .out_granted          (out_granted),
    .out_chosen_partition (out_chosen_partition),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic step_t mk_cfg(input logic [CFG_IDX_W-1:0] sel, input int val);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_sel = sel;
    s.reg_val = CFG_W'(val);
    return s;
  endfunction

  function automatic step_t mk_word(input logic f, input int p, input int a,
                                    input logic fixed, input logic g, input int c);
    step_t s;
    s = '0;
    s.func          = f;
    s.pidx          = PIDX_W'(p);
    s.amt           = AMOUNT_W'(a);
    s.exp_fixed     = fixed;
    s.exp_w.granted = g;
    s.exp_w.chosen  = PIDX_W'(c);
    return s;
  endfunction

  function automatic int searched_count();
    return (piu > PARTITIONS) ? PARTITIONS : int'(piu);
  endfunction

  // index picked under the current policy, -1 when nothing fits
  function automatic int fit_search(input logic [SIZE_BITS-1:0] req);
    int count;
    int pick;
    count = searched_count();
    pick = -1;
    for (int i = 0; i < count; i++) begin
      if (req > free_space[i]) continue;
      if (pick < 0) begin
        pick = i;
        if (pol != POL_BEST && pol != POL_WORST) break;
      end else if (pol == POL_BEST) begin
        if (free_space[i] < free_space[pick]) pick = i;
      end else if (pol == POL_WORST) begin
        if (free_space[i] > free_space[pick]) pick = i;
      end
    end
    return pick;
  endfunction

  task automatic book_word(input logic f, input logic [PIDX_W-1:0] p,
                           input logic [AMOUNT_W-1:0] a, input logic fixed,
                           input grant_t fixed_w);
    int pick;
    grant_t w;
    n_words++;
    if (f == FUNC_LOAD) begin
      n_loads++;
      if (p < PARTITIONS) free_space[p] = SIZE_BITS'(a);
    end else begin
      pick = fit_search(SIZE_BITS'(a));
      w = '0;
      if (pick >= 0) begin
        free_space[pick] = free_space[pick] - SIZE_BITS'(a);
        w.granted = 1'b1;
        w.chosen  = PIDX_W'(pick);
      end
      grant_q.push_back(fixed ? fixed_w : w);
    end
  endtask

  // start is left high; the caller lowers it when a gap follows
  task automatic send_word(input logic f, input logic [PIDX_W-1:0] p,
                           input logic [AMOUNT_W-1:0] a, input logic fixed,
                           input grant_t fixed_w);
    start              <= 1'b1;
    in_func            <= f;
    in_partition_index <= p;
    in_amount          <= a;
    do @(posedge clk); while (busy);
    book_word(f, p, a, fixed, fixed_w);
  endtask

  task automatic rest_after_word(input logic quiet);
    int gap;
    int r;
    logic hold;
    r = $urandom_range(0, 19);
    if (quiet) gap = 0;
    else if (r < 12) gap = $urandom_range(0, 2);
    else if (r < 18) gap = $urandom_range(3, 8);
    else gap = $urandom_range(10, 40);
    hold = ($urandom_range(0, 63) == 0);
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      while (hold && grant_q.size() != 0) @(posedge clk);
    end
  endtask

  // drain outstanding grants, then let a trailing load settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_cfg++;
    if (sel == CFG_POLICY) pol = val[POLICY_W-1:0];
    else piu = val[PIU_W-1:0];
  endtask

  task automatic random_word(input logic quiet);
    logic                f;
    logic [PIDX_W-1:0]   p;
    logic [AMOUNT_W-1:0] a;
    int                  cnt;
    int                  m;
    cnt = searched_count();
    p = PIDX_W'($urandom_range(0, PARTITIONS - 1));
    m = $urandom_range(0, 7);
    f = ($urandom_range(0, 9) < 3) ? FUNC_LOAD : FUNC_ALLOC;
    if (f == FUNC_LOAD) begin
      case (m)
        0: a = '0;
        1: a = '1;
        2: a = free_space[$urandom_range(0, PARTITIONS - 1)];
        3, 4: a = AMOUNT_W'($urandom_range(0, 1023));
        default: a = AMOUNT_W'($urandom);
      endcase
    end else begin
      case (m)
        0: a = '0;
        1: a = '1;
        2, 3: a = (cnt > 0) ? free_space[$urandom_range(0, cnt - 1)] : AMOUNT_W'($urandom);
        4, 5: a = AMOUNT_W'($urandom_range(1, 300));
        6: a = AMOUNT_W'($urandom_range(0, 4095));
        default: a = AMOUNT_W'($urandom);
      endcase
    end
    send_word(f, p, a, 1'b0, '0);
    rest_after_word(quiet);
  endtask

  always @(posedge clk) begin : grant_check
    grant_t w;
    if (rst_n && out_valid === 1'b1) begin
      if (out_granted) grants_seen++;
      else refusals_seen++;
      if (grant_q.size() == 0) begin
        $error("grant word with none expected: granted %0d chosen %0d",
               out_granted, out_chosen_partition);
        errors++;
      end else begin
        w = grant_q.pop_front();
        if (out_granted !== w.granted) begin
          $error("granted: expected %0d, got %0d", w.granted, out_granted);
          errors++;
        end
        if (out_chosen_partition !== w.chosen) begin
          $error("chosen_partition: expected %0d, got %0d", w.chosen, out_chosen_partition);
          errors++;
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int order [PARTITIONS];
    int j;
    int t;
    int n_ph;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOAD;
    in_partition_index = '0;
    in_amount = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_wdata = '0;
    pol = POL_FIRST;
    piu = PIU_RESET;
    for (int i = 0; i < PARTITIONS; i++) free_space[i] = '0;

    // directed: zero count, exact fits, ties, worst-fit refusal, spare policy code
    plan[0]  = mk_cfg(CFG_PARTS, 0);
    plan[1]  = mk_word(FUNC_ALLOC, 0, 0, 1'b1, 1'b0, 0);
    plan[2]  = mk_word(FUNC_ALLOC, 5, 'hFFFF, 1'b1, 1'b0, 0);
    plan[3]  = mk_cfg(CFG_PARTS, 4);
    plan[4]  = mk_cfg(CFG_POLICY, POL_FIRST);
    plan[5]  = mk_word(FUNC_LOAD, 0, 100, 1'b0, 1'b0, 0);
    plan[6]  = mk_word(FUNC_LOAD, 1, 50, 1'b0, 1'b0, 0);
    plan[7]  = mk_word(FUNC_LOAD, 2, 200, 1'b0, 1'b0, 0);
    plan[8]  = mk_word(FUNC_LOAD, 3, 50, 1'b0, 1'b0, 0);
    plan[9]  = mk_word(FUNC_LOAD, 15, 'hFFFF, 1'b0, 1'b0, 0);
    plan[10] = mk_word(FUNC_ALLOC, 0, 100, 1'b0, 1'b0, 0);
    plan[11] = mk_word(FUNC_ALLOC, 9, 60, 1'b0, 1'b0, 0);
    plan[12] = mk_cfg(CFG_POLICY, POL_BEST);
    plan[13] = mk_word(FUNC_ALLOC, 0, 40, 1'b0, 1'b0, 0);
    plan[14] = mk_word(FUNC_ALLOC, 0, 50, 1'b0, 1'b0, 0);
    plan[15] = mk_cfg(CFG_POLICY, POL_WORST);
    plan[16] = mk_word(FUNC_ALLOC, 0, 10, 1'b0, 1'b0, 0);
    plan[17] = mk_word(FUNC_ALLOC, 0, 'hFFFF, 1'b1, 1'b0, 0);
    plan[18] = mk_cfg(CFG_POLICY, POL_SPARE);
    plan[19] = mk_word(FUNC_ALLOC, 15, 0, 1'b0, 1'b0, 0);
    plan[20] = mk_word(FUNC_LOAD, 0, 'hFFFF, 1'b0, 1'b0, 0);
    plan[21] = mk_word(FUNC_ALLOC, 0, 'hFFFF, 1'b0, 1'b0, 0);
    plan[22] = mk_cfg(CFG_PARTS, 1);
    plan[23] = mk_word(FUNC_ALLOC, 0, 1, 1'b1, 1'b0, 0);

    ph_pol[0] = POL_FIRST;  ph_piu[0] = 16;
    ph_pol[1] = POL_BEST;   ph_piu[1] = 16;
    ph_pol[2] = POL_WORST;  ph_piu[2] = 16;
    ph_pol[3] = POL_SPARE;  ph_piu[3] = 8;
    ph_pol[4] = POL_BEST;   ph_piu[4] = 1;
    ph_pol[5] = POL_WORST;  ph_piu[5] = 31;
    ph_pol[6] = POL_FIRST;  ph_piu[6] = 17;
    ph_pol[7] = POL_BEST;   ph_piu[7] = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].is_cfg) begin
        wait_idle();
        cfg_write(plan[k].reg_sel, plan[k].reg_val);
      end else begin
        send_word(plan[k].func, plan[k].pidx, plan[k].amt, plan[k].exp_fixed, plan[k].exp_w);
        rest_after_word(k < 12);
      end
    end

    // load every partition once, in shuffled order, before wider searches
    wait_idle();
    for (int i = 0; i < PARTITIONS; i++) order[i] = i;
    for (int i = PARTITIONS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < PARTITIONS; i++) begin
      send_word(FUNC_LOAD, PIDX_W'(order[i]), AMOUNT_W'($urandom), 1'b0, '0);
      rest_after_word(1'b0);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      cfg_write(CFG_POLICY, CFG_W'(ph_pol[ph]));
      cfg_write(CFG_PARTS, CFG_W'(ph_piu[ph]));
      n_ph = (ph_piu[ph] == 0) ? 40 : 180;
      for (int k = 0; k < n_ph; k++)
        random_word(k >= n_ph / 2 && k < n_ph / 2 + 30);
    end

    start <= 1'b0;
    for (int w = 0; w < 2000 && grant_q.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d grant words never arrived", grant_q.size());
      errors++;
    end

    $display("Covered %0d words (%0d loads), %0d register writes, all four policy codes,",
             n_words, n_loads, n_cfg);
    $display("partition counts 0 to 31; %0d grants and %0d refusals seen.",
             grants_seen, refusals_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
